// ----- sv/srtf_preemptive_scheduler_assert.svh -----
// Assertion macros for the shortest-remaining-time scheduler.
`ifndef SRTF_PREEMPTIVE_SCHEDULER_ASSERT_SVH
`define SRTF_PREEMPTIVE_SCHEDULER_ASSERT_SVH
// An implication checked at every clock edge outside reset.
`define SRTF_ASSERT_IMP(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);
// A next-cycle implication checked outside reset.
`define SRTF_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);
`endif

// ----- sv/srtf_pkg.sv -----
// Shared types and constants for the shortest-remaining-time scheduler.
`default_nettype none
package srtf_pkg;
   localparam int SlotsDefault    = 16;
   localparam int TimeBitsDefault = 16;
   localparam logic [1:0] ST_FREE  = 2'd0;
   localparam logic [1:0] ST_READY = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;
   localparam logic [1:0] ST_RUN   = 2'd3;
   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_TICK = 1'b1;
   // Commands broadcast to every cell during one pass over the chain.
   localparam logic [2:0] CMD_NONE   = 3'd0;
   localparam logic [2:0] CMD_STORE  = 3'd1; // write new job into target cell
   localparam logic [2:0] CMD_IOAGE  = 3'd2; // age waiting cells, apply mask
   localparam logic [2:0] CMD_SETST  = 3'd3; // set stage of target cell
   localparam logic [2:0] CMD_RUNSTEP= 3'd4; // start/consume in target, age ready
   localparam logic [2:0] CMD_RETIRE = 3'd6; // free target cell
endpackage
`default_nettype wire

// ----- sv/srtf_cell.sv -----
// One job slot: holds its state and joins the ready-job search as the sweep passes.
`default_nettype none
module srtf_cell #(
   parameter int SLOTS = srtf_pkg::SlotsDefault,
   parameter int TB    = srtf_pkg::TimeBitsDefault,
   parameter int IDX   = 0
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [2:0]               cmd,
   input  wire logic [$clog2(SLOTS)-1:0] target,
   input  wire logic [1:0]               new_stage,
   input  wire logic [7:0]               new_id,
   input  wire logic [TB-1:0]            new_rem,
   input  wire logic [TB-1:0]            now_time,
   input  wire logic                     mask_bit,
   output logic [1:0]                    stage,
   output logic [7:0]                    owner,
   output logic [TB-1:0]                 remaining,
   output logic                          started,
   output logic [TB-1:0]                 first_run,
   output logic [TB-1:0]                 ready_wait,
   output logic [TB-1:0]                 io_wait
);
   import srtf_pkg::*;
   localparam int IW = $clog2(SLOTS);
   localparam logic [TB-1:0] TMAX = {TB{1'b1}};
   logic [1:0] stage_ff, stage_in;
   logic started_ff, started_in;
   logic [7:0] owner_ff;
   logic [TB-1:0] rem_ff, start_ff, rw_ff, io_ff;
   logic hit;

   assign hit = (target == IW'(IDX));

   always_comb begin
      stage_in = stage_ff;
      started_in = started_ff;
      case (cmd)
         CMD_STORE: if (hit) begin
            stage_in = ST_READY;
            started_in = 1'b0;
         end
         CMD_IOAGE: if (stage_ff == ST_WAIT && mask_bit) stage_in = ST_READY;
         CMD_SETST: if (hit) begin
            stage_in = new_stage;
            // A job that parks on I/O has been started even if it never ran.
            if (new_stage == ST_WAIT) started_in = 1'b1;
         end
         CMD_RUNSTEP: if (hit) started_in = 1'b1;
         CMD_RETIRE: if (hit) begin
            stage_in = ST_FREE;
            started_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= ST_FREE;
         started_ff <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         started_ff <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd)
         CMD_STORE: if (hit) begin
            owner_ff <= new_id;
            rem_ff <= new_rem;
            start_ff <= '0;
            rw_ff <= '0;
            io_ff <= '0;
         end
         CMD_IOAGE: if (stage_ff == ST_WAIT && io_ff != TMAX) io_ff <= io_ff + 1'b1;
         CMD_RUNSTEP: begin
            if (hit) begin
               if (!started_ff) start_ff <= now_time;
               rem_ff <= rem_ff - 1'b1;
            end
            if (stage_ff == ST_READY && rw_ff != TMAX) rw_ff <= rw_ff + 1'b1;
         end
         CMD_SETST: if (hit && new_stage == ST_WAIT && !started_ff) start_ff <= now_time;
         default: ;
      endcase
   end

   assign stage = stage_ff;
   assign owner = owner_ff;
   assign remaining = rem_ff;
   assign started = started_ff;
   assign first_run = start_ff;
   assign ready_wait = rw_ff;
   assign io_wait = io_ff;
endmodule
`default_nettype wire

// ----- sv/srtf_preemptive_scheduler.sv -----
// Top level of the shortest-remaining-time scheduler: sequencer over a row of slot cells.
//
//  channel | ports                                  | direction
//  req     | req_valid req_stall req_op ..          | in
//  rsp     | rsp_valid rsp_stall rsp_accepted ..    | out
//
// A tick that runs the selected job goes from I/O ageing straight to the run step
// and the output register. Otherwise a tick may scan the cell row twice for the
// ready job, once per pass over every slot, and an add first scans for the
// lowest free slot. Reset is synchronous and clears all slots to free. The result
// stays in the output register until taken; a new item is accepted once the
// previous result has been taken or is being taken.
`default_nettype none
`include "srtf_preemptive_scheduler_assert.svh"
module srtf_preemptive_scheduler #(
   parameter int SLOTS     = srtf_pkg::SlotsDefault,
   parameter int TIME_BITS = srtf_pkg::TimeBitsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_op,
   input  wire logic [7:0]  req_job_id,
   input  wire logic [15:0] req_run_time,
   input  wire logic        req_io_call,
   input  wire logic [15:0] req_io_done_mask,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_accepted,
   output logic [3:0]       rsp_slot,
   output logic [15:0]      rsp_now,
   output logic             rsp_running_valid,
   output logic [7:0]       rsp_running_id,
   output logic             rsp_done_valid,
   output logic [7:0]       rsp_done_id,
   output logic [15:0]      rsp_done_ready_time,
   output logic [15:0]      rsp_done_io_time,
   output logic [15:0]      rsp_done_system_time
);
   import srtf_pkg::*;
   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int TB = TIME_BITS;
   localparam logic [TB-1:0] TMAX = {TB{1'b1}};

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_FREE   = 4'd1; // scan for lowest free slot
   localparam logic [3:0] S_STORE  = 4'd2;
   localparam logic [3:0] S_REQ    = 4'd3; // running job back to ready
   localparam logic [3:0] S_SCAN   = 4'd4; // ready-job search
   localparam logic [3:0] S_PICK   = 4'd5; // apply search result
   localparam logic [3:0] S_IOAGE  = 4'd6;
   localparam logic [3:0] S_EXEC   = 4'd7; // run, retire or park
   localparam logic [3:0] S_OUT    = 4'd8;

   // What follows the ready-job search.
   localparam logic [1:0] AFT_OUT   = 2'd0; // just report
   localparam logic [1:0] AFT_EXEC  = 2'd1; // continue the pass, or advance time
   localparam logic [1:0] AFT_IDLE  = 2'd2; // advance time if nothing found

   logic [3:0] state_ff, state_in;
   logic [1:0] after_ff;
   logic [CW-1:0] cnt_ff;
   logic op_ff, ioreq_ff;
   logic [7:0] id_ff;
   logic [TB-1:0] rt_ff;
   logic [15:0] mask_ff;
   logic [TB-1:0] now_ff;
   logic cur_v_ff;
   logic [IW-1:0] cur_ff;
   logic best_f_ff;
   logic [IW-1:0] best_ff;
   logic [2:0] cmd;
   logic [IW-1:0] target;
   logic [1:0] new_stage;

   logic [1:0]    c_stage [SLOTS];
   logic [7:0]    c_owner [SLOTS];
   logic [TB-1:0] c_rem   [SLOTS];
   logic          c_st    [SLOTS];
   logic [TB-1:0] c_start [SLOTS];
   logic [TB-1:0] c_rw    [SLOTS];
   logic [TB-1:0] c_io    [SLOTS];

   logic out_v_ff;
   logic o_acc_ff, o_dv_ff;
   logic [3:0] o_slot_ff;
   logic [7:0] o_did_ff;
   logic [15:0] o_drt_ff, o_dio_ff, o_dsys_ff;

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      srtf_cell #(.SLOTS(SLOTS), .TB(TB), .IDX(g)) u_cell (
         .clock(clock), .reset(reset), .cmd(cmd), .target(target),
         .new_stage(new_stage), .new_id(id_ff), .new_rem(rt_ff),
         .now_time(now_ff), .mask_bit(mask_ff[g % 16]),
         .stage(c_stage[g]), .owner(c_owner[g]), .remaining(c_rem[g]),
         .started(c_st[g]), .first_run(c_start[g]), .ready_wait(c_rw[g]),
         .io_wait(c_io[g]));
   end

   logic [IW-1:0] sidx;
   logic better;
   logic [TB-1:0] rt_sat;
   assign sidx = cnt_ff[IW-1:0];
   assign better = (c_stage[sidx] == ST_READY) && (!best_f_ff ||
      c_rem[sidx] < c_rem[best_ff] ||
      (c_rem[sidx] == c_rem[best_ff] && c_owner[sidx] < c_owner[best_ff]));
   if (TB >= 16) begin : g_rtw
      assign rt_sat = TB'(req_run_time);
   end else begin : g_rtn
      assign rt_sat = (req_run_time > 16'(TMAX)) ? TMAX : req_run_time[TB-1:0];
   end

   logic busy_out;
   assign busy_out = out_v_ff && rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || busy_out;
   logic take_in;
   assign take_in = (state_ff == S_IDLE) && req_valid && !busy_out;
   logic scan_last;
   assign scan_last = (cnt_ff == CW'(SLOTS - 1));

   always_comb begin
      state_in = state_ff;
      cmd = CMD_NONE;
      target = cur_ff;
      new_stage = ST_READY;
      unique case (state_ff)
         S_IDLE: if (req_valid && !busy_out) state_in = (req_op == OP_ADD) ? S_FREE : S_IOAGE;
         S_FREE: begin
            target = sidx;
            if (c_stage[sidx] == ST_FREE) state_in = S_STORE;
            else if (scan_last) state_in = S_OUT;
         end
         S_STORE: begin
            cmd = CMD_STORE;
            target = sidx;
            state_in = S_REQ;
         end
         S_REQ: begin
            if (cur_v_ff) cmd = CMD_SETST;
            state_in = S_SCAN;
         end
         S_SCAN: if (scan_last) state_in = S_PICK;
         S_PICK: begin
            target = best_ff;
            new_stage = ST_RUN;
            if (best_f_ff) cmd = CMD_SETST;
            state_in = (after_ff == AFT_EXEC && best_f_ff) ? S_EXEC : S_OUT;
         end
         S_IOAGE: begin
            cmd = CMD_IOAGE;
            state_in = cur_v_ff ? S_EXEC : S_SCAN;
         end
         S_EXEC: begin
            state_in = S_OUT;
            if (c_rem[cur_ff] == '0) begin
               cmd = CMD_RETIRE;
               state_in = S_SCAN;
            end else if (ioreq_ff) begin
               // Parking also records the first start time in the cell.
               cmd = CMD_SETST;
               new_stage = ST_WAIT;
               state_in = S_SCAN;
            end else cmd = CMD_RUNSTEP;
         end
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         now_ff <= TB'(1);
         cur_v_ff <= 1'b0;
         cur_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_v_ff && !rsp_stall) out_v_ff <= 1'b0;
         if (state_ff == S_OUT) out_v_ff <= 1'b1;
         unique case (state_ff)
            S_IDLE: ;
            S_FREE: ;
            S_STORE: ;
            S_REQ: cur_v_ff <= 1'b0;
            S_SCAN: ;
            S_PICK: begin
               cur_v_ff <= best_f_ff;
               cur_ff <= best_f_ff ? best_ff : '0;
               if (!best_f_ff && after_ff != AFT_OUT && now_ff != TMAX)
                  now_ff <= now_ff + 1'b1;
            end
            S_IOAGE: ;
            S_EXEC: begin
               if (c_rem[cur_ff] == '0) cur_v_ff <= 1'b0;
               else if (ioreq_ff) cur_v_ff <= 1'b0;
               else if (now_ff != TMAX) now_ff <= now_ff + 1'b1;
            end
            S_OUT: ;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE) begin
         op_ff <= req_op;
         id_ff <= req_job_id;
         rt_ff <= rt_sat;
         ioreq_ff <= req_io_call;
         mask_ff <= req_io_done_mask;
         cnt_ff <= '0;
      end
      // The result register holds until the next beat is taken.
      if (take_in) begin
         o_acc_ff <= 1'b0;
         o_slot_ff <= '0;
         o_dv_ff <= 1'b0;
         o_did_ff <= '0;
         o_drt_ff <= '0;
         o_dio_ff <= '0;
         o_dsys_ff <= '0;
      end
      if (state_ff == S_FREE) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (c_stage[sidx] == ST_FREE) begin
            cnt_ff <= cnt_ff;
            o_acc_ff <= 1'b1;
            o_slot_ff <= 4'(sidx);
         end
      end
      if (state_ff == S_REQ || state_ff == S_IOAGE || state_ff == S_EXEC) begin
         cnt_ff <= '0;
         best_f_ff <= 1'b0;
         best_ff <= '0;
      end
      if (state_ff == S_REQ) after_ff <= AFT_OUT;
      if (state_ff == S_IOAGE) after_ff <= AFT_EXEC;
      if (state_ff == S_EXEC) begin
         after_ff <= (c_rem[cur_ff] == '0) ? AFT_OUT : AFT_IDLE;
         if (c_rem[cur_ff] == '0) begin
            o_dv_ff <= 1'b1;
            o_did_ff <= c_owner[cur_ff];
            o_drt_ff <= 16'(c_rw[cur_ff]);
            o_dio_ff <= 16'(c_io[cur_ff]);
            o_dsys_ff <= (c_st[cur_ff] && now_ff >= c_start[cur_ff]) ?
               16'(now_ff - c_start[cur_ff]) : 16'd0;
         end
      end
      if (state_ff == S_SCAN) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (better) begin
            best_f_ff <= 1'b1;
            best_ff <= sidx;
         end
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_accepted = o_acc_ff;
   assign rsp_slot = o_slot_ff;
   assign rsp_now = 16'(now_ff);
   assign rsp_running_valid = cur_v_ff;
   assign rsp_running_id = cur_v_ff ? c_owner[cur_ff] : 8'd0;
   assign rsp_done_valid = o_dv_ff;
   assign rsp_done_id = o_did_ff;
   assign rsp_done_ready_time = o_drt_ff;
   assign rsp_done_io_time = o_dio_ff;
   assign rsp_done_system_time = o_dsys_ff;

   logic unused_op;
   assign unused_op = op_ff;

   `SRTF_ASSERT_IMP(a_stall_busy, clock, reset, state_ff != S_IDLE, req_stall,
      "input taken while busy")
   `SRTF_ASSERT_IMP(a_run_stage, clock, reset, cur_v_ff && state_ff == S_IDLE,
      c_stage[cur_ff] == ST_RUN, "selected job not in running stage")
   `SRTF_ASSERT_NEXT(a_out_after, clock, reset, state_ff == S_OUT, rsp_valid,
      "result not shown after pass")
endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking testbench for the shortest-remaining-time scheduler.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import srtf_pkg::*;

   localparam int NSLOT = 16;
   localparam int WDOG_LIMIT = 20000;
   localparam logic [15:0] TSAT = 16'hFFFF;

   typedef struct packed {
      logic        accepted;
      logic [3:0]  slot;
      logic [15:0] now;
      logic        running_valid;
      logic [7:0]  running_id;
      logic        done_valid;
      logic [7:0]  done_id;
      logic [15:0] done_ready_time;
      logic [15:0] done_io_time;
      logic [15:0] done_system_time;
   } sched_result_t;

   typedef struct {
      logic        op;
      logic [7:0]  job_id;
      logic [15:0] run_time;
      logic        io_call;
      logic [15:0] io_done_mask;
      logic        has_fixed;
      sched_result_t fixed;
   } beat_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_op = 1'b0;
   logic [7:0] req_job_id = '0;
   logic [15:0] req_run_time = '0;
   logic req_io_call = 1'b0;
   logic [15:0] req_io_done_mask = '0;
   logic rsp_stall = 1'b0;
   wire req_stall, rsp_valid;
   sched_result_t got;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   srtf_preemptive_scheduler dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_job_id(req_job_id), .req_run_time(req_run_time),
      .req_io_call(req_io_call), .req_io_done_mask(req_io_done_mask),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_accepted(got.accepted), .rsp_slot(got.slot), .rsp_now(got.now),
      .rsp_running_valid(got.running_valid), .rsp_running_id(got.running_id),
      .rsp_done_valid(got.done_valid), .rsp_done_id(got.done_id),
      .rsp_done_ready_time(got.done_ready_time), .rsp_done_io_time(got.done_io_time),
      .rsp_done_system_time(got.done_system_time)
   );

   // Shadow copy of the scheduler state.
   logic [15:0] sh_now;
   logic [1:0]  sh_stage [NSLOT];
   logic [7:0]  sh_owner [NSLOT];
   logic [15:0] sh_left [NSLOT];
   logic        sh_started [NSLOT];
   logic [15:0] sh_start [NSLOT];
   logic [15:0] sh_rwait [NSLOT];
   logic [15:0] sh_iowait [NSLOT];
   logic [3:0]  sh_cur;
   logic        sh_cur_ok;

   sched_result_t pending_results [$];
   beat_t         beats [$];
   int errors = 0;
   int idle_cycles = 0;

   function automatic logic [15:0] sat_up(logic [15:0] v);
      return (v == TSAT) ? TSAT : v + 16'd1;
   endfunction

   task automatic shadow_reset();
      sh_now = 16'd1;
      for (int i = 0; i < NSLOT; i++) begin
         sh_stage[i] = ST_FREE; sh_owner[i] = '0; sh_left[i] = '0;
         sh_started[i] = 0; sh_start[i] = '0; sh_rwait[i] = '0; sh_iowait[i] = '0;
      end
      sh_cur = '0; sh_cur_ok = 0;
   endtask

   task automatic pick_shortest();
      int best;
      bit found;
      best = 0; found = 0;
      for (int i = 0; i < NSLOT; i++) begin
         if (sh_stage[i] != ST_READY) continue;
         if (!found || sh_left[i] < sh_left[best] ||
             (sh_left[i] == sh_left[best] && sh_owner[i] < sh_owner[best])) begin
            best = i; found = 1;
         end
      end
      sh_cur_ok = found;
      sh_cur = found ? best[3:0] : 4'd0;
      if (found) sh_stage[best] = ST_RUN;
   endtask

   function automatic int free_count();
      int n;
      n = 0;
      for (int i = 0; i < NSLOT; i++) if (sh_stage[i] == ST_FREE) n++;
      return n;
   endfunction

   task automatic schedule_beat(input beat_t b, output sched_result_t r);
      int i, c;
      r = '0;
      if (b.op == OP_ADD) begin
         for (i = 0; i < NSLOT; i++) if (sh_stage[i] == ST_FREE) break;
         if (i < NSLOT) begin
            r.accepted = 1; r.slot = i[3:0];
            sh_stage[i] = ST_READY; sh_owner[i] = b.job_id; sh_left[i] = b.run_time;
            sh_started[i] = 0; sh_start[i] = '0; sh_rwait[i] = '0; sh_iowait[i] = '0;
            if (sh_cur_ok) sh_stage[sh_cur] = ST_READY;
            pick_shortest();
         end
      end else begin
         for (i = 0; i < NSLOT; i++) begin
            if (sh_stage[i] != ST_WAIT) continue;
            sh_iowait[i] = sat_up(sh_iowait[i]);
            if (b.io_done_mask[i]) sh_stage[i] = ST_READY;
         end
         do begin
            if (!sh_cur_ok) begin
               pick_shortest();
               if (!sh_cur_ok) begin sh_now = sat_up(sh_now); break; end
            end
            c = sh_cur;
            if (sh_left[c] == 0) begin
               r.done_valid = 1; r.done_id = sh_owner[c];
               r.done_ready_time = sh_rwait[c]; r.done_io_time = sh_iowait[c];
               if (sh_started[c] && sh_now >= sh_start[c])
                  r.done_system_time = sh_now - sh_start[c];
               sh_stage[c] = ST_FREE; sh_started[c] = 0; sh_cur_ok = 0;
               pick_shortest();
               break;
            end
            if (!sh_started[c]) begin sh_started[c] = 1; sh_start[c] = sh_now; end
            if (b.io_call) begin
               sh_stage[c] = ST_WAIT; sh_cur_ok = 0;
               pick_shortest();
               if (!sh_cur_ok) sh_now = sat_up(sh_now);
               break;
            end
            for (i = 0; i < NSLOT; i++)
               if (sh_stage[i] == ST_READY) sh_rwait[i] = sat_up(sh_rwait[i]);
            sh_now = sat_up(sh_now);
            sh_left[c] = sh_left[c] - 16'd1;
         end while (0);
      end
      r.now = sh_now;
      r.running_valid = sh_cur_ok;
      r.running_id = sh_cur_ok ? sh_owner[sh_cur] : 8'd0;
   endtask

   task automatic report_mismatch(input string what, input logic [15:0] g,
                                  input logic [15:0] e);
      errors++;
      $display("mismatch %s: got %0h expected %0h at %0t", what, g, e, $realtime);
   endtask

   function automatic beat_t mk(logic op, logic [7:0] id, logic [15:0] rt,
                                logic io, logic [15:0] mask);
      beat_t b;
      b.op = op; b.job_id = id; b.run_time = rt; b.io_call = io;
      b.io_done_mask = mask; b.has_fixed = 0; b.fixed = '0;
      return b;
   endfunction

   // Result side: compare against the oldest expectation.
   always @(posedge clock) begin
      sched_result_t e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            errors++;
            $display("unexpected result beat at %0t", $realtime);
         end else begin
            e = pending_results.pop_front();
            if (got.accepted !== e.accepted) report_mismatch("accepted", got.accepted, e.accepted);
            if (got.slot !== e.slot) report_mismatch("slot", got.slot, e.slot);
            if (got.now !== e.now) report_mismatch("now", got.now, e.now);
            if (got.running_valid !== e.running_valid)
               report_mismatch("running_valid", got.running_valid, e.running_valid);
            if (got.running_id !== e.running_id)
               report_mismatch("running_id", got.running_id, e.running_id);
            if (got.done_valid !== e.done_valid)
               report_mismatch("done_valid", got.done_valid, e.done_valid);
            if (got.done_id !== e.done_id) report_mismatch("done_id", got.done_id, e.done_id);
            if (got.done_ready_time !== e.done_ready_time)
               report_mismatch("done_ready_time", got.done_ready_time, e.done_ready_time);
            if (got.done_io_time !== e.done_io_time)
               report_mismatch("done_io_time", got.done_io_time, e.done_io_time);
            if (got.done_system_time !== e.done_system_time)
               report_mismatch("done_system_time", got.done_system_time, e.done_system_time);
         end
      end
   end

   // Receiver stall pattern: calm stretches and busy stretches.
   always @(posedge clock) begin
      int mode;
      if (reset) rsp_stall <= 1'b0;
      else begin
         mode = ($realtime / 2000.0) > 0 ? (int'($realtime) / 2000) % 3 : 0;
         if (mode == 0) rsp_stall <= 1'b0;
         else if (mode == 1) rsp_stall <= ($urandom_range(0, 3) == 0);
         else rsp_stall <= ($urandom_range(0, 1) == 0);
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_beat(input beat_t b);
      sched_result_t r;
      req_valid <= 1'b1;
      req_op <= b.op; req_job_id <= b.job_id; req_run_time <= b.run_time;
      req_io_call <= b.io_call; req_io_done_mask <= b.io_done_mask;
      do @(posedge clock); while (req_stall);
      schedule_beat(b, r);
      if (b.has_fixed && r !== b.fixed) begin
         errors++;
         $display("directed row disagrees with prediction at %0t", $realtime);
      end
      pending_results.push_back(b.has_fixed ? b.fixed : r);
   endtask

   task automatic send_gap();
      int g;
      g = $urandom_range(1, 6);
      req_valid <= 1'b0;
      req_op <= 1'($urandom); req_job_id <= 8'($urandom); req_run_time <= 16'($urandom);
      req_io_call <= 1'($urandom); req_io_done_mask <= 16'($urandom);
      repeat (g) @(posedge clock);
   endtask

   initial begin
      beat_t b;
      int burst, kind;
      shadow_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows: first tick on an empty table only advances time.
      b = mk(OP_TICK, 8'd0, 16'd0, 1'b0, 16'h0000);
      b.has_fixed = 1; b.fixed = '0; b.fixed.now = 16'd2;
      beats.push_back(b);
      b = mk(OP_ADD, 8'd255, 16'hFFFF, 1'b0, 16'h0000);
      b.has_fixed = 1; b.fixed = '0; b.fixed.accepted = 1; b.fixed.now = 16'd2;
      b.fixed.running_valid = 1; b.fixed.running_id = 8'd255;
      beats.push_back(b);
      beats.push_back(mk(OP_ADD, 8'd0, 16'd1, 1'b0, 16'h0));
      beats.push_back(mk(OP_ADD, 8'd7, 16'd0, 1'b0, 16'h0));   // never started
      beats.push_back(mk(OP_ADD, 8'd3, 16'd1, 1'b0, 16'h0));   // tie on time
      beats.push_back(mk(OP_TICK, 8'd0, 16'd0, 1'b0, 16'h0));
      beats.push_back(mk(OP_TICK, 8'd0, 16'd0, 1'b0, 16'h0));
      beats.push_back(mk(OP_TICK, 8'd0, 16'd0, 1'b1, 16'h0));  // I/O park
      beats.push_back(mk(OP_TICK, 8'd0, 16'd0, 1'b1, 16'h0));
      beats.push_back(mk(OP_TICK, 8'd0, 16'd0, 1'b0, 16'hFFFF));
      beats.push_back(mk(OP_TICK, 8'hAA, 16'h5555, 1'b0, 16'h0));
      beats.push_back(mk(OP_TICK, 8'h55, 16'hAAAA, 1'b0, 16'h0));
      for (int i = 0; i < 16; i++)                              // fill then overflow
         beats.push_back(mk(OP_ADD, 8'(i * 17), 16'(i + 2), 1'b0, 16'h0));
      foreach (beats[i]) begin
         send_beat(beats[i]);
         if ($urandom_range(0, 2) == 0) send_gap();
      end

      // Random traffic: mostly short jobs, an occasional huge one, ticks to drain.
      for (int n = 0; n < 750; ) begin
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst && n < 750; k++, n++) begin
            kind = $urandom_range(0, 9);
            if (kind < 3)
               b = mk(OP_ADD, 8'($urandom), (kind == 0 && $urandom_range(0, 15) == 0) ?
                      16'($urandom) : 16'($urandom_range(0, 12)), 1'($urandom),
                      16'($urandom));
            else
               b = mk(OP_TICK, 8'($urandom), 16'($urandom), ($urandom_range(0, 5) == 0),
                      ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'h0);
            if (free_count() == 0 && kind < 3 && $urandom_range(0, 3) != 0)
               b.op = OP_TICK;
            send_beat(b);
         end
         if ($urandom_range(0, 3) != 0) send_gap();
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
`default_nettype wire
